/* hw/rtl/stl_pkg.sv */
`default_nettype none
package stl_pkg;

    typedef enum logic [1:0] {
        CMD_SET_COUNT   = 2'd0,
        CMD_WRITE_ENTRY = 2'd1,
        CMD_WRITE_WORD  = 2'd2,
        CMD_QUERY       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_HIT        = 2'd0,
        ST_ABSENT     = 2'd1,
        ST_MISMATCH   = 2'd2,
        ST_BAD_MODULE = 2'd3
    } status_t;

    localparam int ARG_LANES = 4;

    // one queued transaction between front and back
    typedef struct packed {
        logic [1:0]  cmd;
        logic        bad_module;
        logic [7:0]  module_num;
        logic [9:0]  index_or_count;
        logic [31:0] lookup_key;
        logic [31:0] entry_token;
        logic [2:0]  num_args;
        logic [9:0]  arg_start;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic [31:0] arg2;
        logic [31:0] arg3;
    } txn_t;

endpackage
`default_nettype wire

/* hw/rtl/stl_front.sv */
`default_nettype none
module stl_front #(
    parameter int MAX_MODULES = 16,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   command,
    input  wire logic [7:0]   module_num,
    input  wire logic [9:0]   index_or_count,
    input  wire logic [31:0]  lookup_key,
    input  wire logic [31:0]  entry_token,
    input  wire logic [2:0]   num_args,
    input  wire logic [9:0]   arg_start,
    input  wire logic [31:0]  arg0,
    input  wire logic [31:0]  arg1,
    input  wire logic [31:0]  arg2,
    input  wire logic [31:0]  arg3,
    output logic              q_valid,
    output stl_pkg::txn_t     q_txn,
    input  wire logic         q_pop
);
    import stl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    txn_t             fifo_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             push;
    txn_t             in_txn;

    assign busy = (cnt_reg == (PW+1)'(DEPTH));
    assign push = start && !busy;

    always_comb
    begin
        in_txn.cmd            = command;
        in_txn.bad_module     = ({24'd0, module_num} >= 32'(MAX_MODULES));
        in_txn.module_num     = module_num;
        in_txn.index_or_count = index_or_count;
        in_txn.lookup_key     = lookup_key;
        in_txn.entry_token    = entry_token;
        in_txn.num_args       = num_args;
        in_txn.arg_start      = arg_start;
        in_txn.arg0           = arg0;
        in_txn.arg1           = arg1;
        in_txn.arg2           = arg2;
        in_txn.arg3           = arg3;
    end

    assign q_valid = (cnt_reg != '0);
    assign q_txn   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_txn;
    end

endmodule
`default_nettype wire

/* hw/rtl/stl_back.sv */
`default_nettype none
module stl_back #(
    parameter int MAX_MODULES   = 16,
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_ARG_WORDS = 1024,
    parameter int MAX_ARGS      = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire stl_pkg::txn_t q_txn,
    output logic               q_pop,
    output logic               done,
    output logic [1:0]         status,
    output logic [31:0]        result_token
);
    import stl_pkg::*;

    localparam int MW  = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int WW  = $clog2(MAX_ARG_WORDS);
    localparam int EAW = MW + EW;
    localparam int WAW = MW + WW;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SRCH   = 8'b0000_0010,
        S_SCMP   = 8'b0000_0100,
        S_LEFT   = 8'b0000_1000,
        S_LCMP   = 8'b0001_0000,
        S_ENTRY  = 8'b0010_0000,
        S_ARG    = 8'b0100_0000,
        S_ECHK   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_mem [MAX_MODULES];
    logic [31:0]   key_mem   [2**EAW];
    logic [31:0]   res_mem   [2**EAW];
    logic [12:0]   info_mem  [2**EAW];
    logic [31:0]   word_mem  [2**WAW];

    txn_t           cur_reg;
    logic [MW-1:0]  mod_reg;
    logic [CW-1:0]  n_reg;
    logic [CW:0]    lo_reg, lo_next, hi_reg, hi_next;   // hi kept +1 to avoid signs
    logic [EW-1:0]  mid_reg, mid_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [2:0]     ai_reg, ai_next;
    logic [2:0]     ecnt_reg;
    logic [10:0]    wptr_reg;

    logic [EAW-1:0] key_addr;
    logic [31:0]    key_rd_reg, res_rd_reg, word_rd_reg;
    logic [12:0]    info_rd_reg;
    logic [EAW-1:0] ent_addr;

    logic           done_next;
    logic [1:0]     status_next;
    logic [31:0]    tok_next;
    logic           load_cur;
    logic           ent_ok, arg_ok;
    logic [31:0]    qarg;
    logic [CW:0]    sum_lh;

    logic           run_reg, run_next;
    logic [1:0]     status_fix;
    logic [EAW-1:0] key_addr_eff;
    logic           fwd_ok;
    state_t         state_fix;
    logic           done_fix;
    logic [1:0]     st_fix2;

    // widths of cur fields into MW
    logic [MW-1:0]  in_mod;
    assign in_mod = q_txn.module_num[MW-1:0];

    assign q_pop = q_valid && (state_reg == S_IDLE);
    assign load_cur = q_pop;

    always_comb
    begin
        case (ai_reg)
            3'd0:    qarg = cur_reg.arg0;
            3'd1:    qarg = cur_reg.arg1;
            3'd2:    qarg = cur_reg.arg2;
            default: qarg = cur_reg.arg3;
        endcase
    end

    assign sum_lh = lo_reg + hi_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        e_next      = e_reg;
        ai_next     = ai_reg;
        done_next   = 1'b0;
        status_next = ST_ABSENT;
        tok_next    = '0;
        key_addr    = {mod_reg, mid_reg};
        ent_ok      = 1'b0;
        arg_ok      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && q_txn.cmd == CMD_QUERY)
                begin
                    if (q_txn.bad_module)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BAD_MODULE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = {1'b0, count_mem[in_mod]};
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (lo_reg >= hi_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_ABSENT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mid_next   = sum_lh[EW:1];
                    key_addr   = {mod_reg, sum_lh[EW:1]};
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (key_rd_reg < cur_reg.lookup_key)
                begin
                    lo_next    = (CW+1)'(mid_reg) + 1'b1;
                    state_next = S_SRCH;
                end
                else if (key_rd_reg > cur_reg.lookup_key)
                begin
                    hi_next    = (CW+1)'(mid_reg);
                    state_next = S_SRCH;
                end
                else
                begin
                    e_next     = mid_reg;
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                // walk down while the previous key still equals the query key
                if (e_reg == '0)
                    state_next = S_ENTRY;
                else
                begin
                    key_addr   = {mod_reg, e_reg - 1'b1};
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (!run_reg && key_rd_reg == cur_reg.lookup_key)
                begin
                    e_next     = e_reg - 1'b1;
                    state_next = S_LEFT;
                end
                else
                    state_next = S_ENTRY;
            end
            S_ENTRY:
            begin
                ai_next    = '0;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                // info/result registered for entry e; test count, then walk args
                if (info_rd_reg[12:10] == cur_reg.num_args &&
                    cur_reg.num_args <= 3'(MAX_ARGS))
                begin
                    if (cur_reg.num_args == '0)
                        ent_ok = 1'b1;
                    else
                        state_next = S_ARG;
                end
                if (state_next != S_ARG)
                begin
                    if (ent_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_HIT;
                        tok_next    = res_rd_reg;
                        state_next  = S_IDLE;
                    end
                    else
                        state_next = S_ENTRY;
                end
            end
            S_ARG:
            begin
                // word_rd_reg holds word for ai_reg (read issued last cycle)
                arg_ok = (wptr_reg < 11'(MAX_ARG_WORDS)) && (word_rd_reg == qarg);
                if (!arg_ok)
                    state_next = S_ENTRY;
                else if (ai_reg + 1'b1 == ecnt_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_HIT;
                    tok_next    = res_rd_reg;
                    state_next  = S_IDLE;
                end
                else
                    ai_next = ai_reg + 1'b1;
            end
            default: state_next = S_IDLE;
        endcase

        // step to next entry of the run after a failed check
        if (state_reg != S_LCMP && state_reg != S_LEFT && state_reg != S_ENTRY &&
            state_next == S_ENTRY)
        begin
            e_next = e_reg + 1'b1;
            if ({1'b0, e_reg} + 1'b1 >= (EW+1)'(n_reg))
            begin
                done_next   = 1'b1;
                status_next = ST_MISMATCH;
                state_next  = S_IDLE;
            end
            else
                state_next = S_LEFT;   // reuse key read, see below
        end
    end

    // S_LEFT after a failed entry needs the key of e; mark via run flag
    always_comb
    begin
        run_next = run_reg;
        if (state_reg == S_SCMP)
            run_next = 1'b0;
        else if (state_reg == S_LCMP && key_rd_reg != cur_reg.lookup_key)
            run_next = 1'b1;
        else if (state_reg == S_LEFT && e_reg == '0)
            run_next = 1'b1;
        status_fix = status_next;
    end

    // in run mode, S_LEFT reads key of e (forward check) instead of e-1
    assign ent_addr  = {mod_reg, e_next};

    assign key_addr_eff = (state_reg == S_LEFT && run_reg) ? {mod_reg, e_reg} : key_addr;
    assign fwd_ok = (key_rd_reg == cur_reg.lookup_key);

    always_comb
    begin
        state_fix = state_next;
        done_fix  = done_next;
        st_fix2   = status_fix;
        if (state_reg == S_LEFT && run_reg)
            state_fix = S_LCMP;
        if (state_reg == S_LCMP && run_reg)
        begin
            if (fwd_ok)
                state_fix = S_ENTRY;
            else
            begin
                state_fix = S_IDLE;
                done_fix  = 1'b1;
                st_fix2   = ST_MISMATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            run_reg   <= 1'b0;
            for (int m = 0; m < MAX_MODULES; m++)
                count_mem[m] <= '0;
        end
        else
        begin
            state_reg <= state_fix;
            done      <= done_fix;
            run_reg   <= run_next;
            if (q_pop && !q_txn.bad_module && q_txn.cmd == CMD_SET_COUNT)
                count_mem[in_mod] <= ({22'd0, q_txn.index_or_count} > 32'(MAX_ENTRIES))
                                     ? CW'(MAX_ENTRIES) : CW'(q_txn.index_or_count);
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        e_reg    <= e_next;
        ai_reg   <= ai_next;
        status   <= st_fix2;
        result_token <= (st_fix2 == ST_HIT) ? tok_next : '0;
        if (load_cur)
        begin
            cur_reg <= q_txn;
            mod_reg <= in_mod;
            n_reg   <= count_mem[in_mod];
        end
        key_rd_reg  <= key_mem[key_addr_eff];
        info_rd_reg <= info_mem[ent_addr];
        res_rd_reg  <= res_mem[ent_addr];
        if (state_reg == S_ECHK)
        begin
            ecnt_reg <= info_rd_reg[12:10];
            wptr_reg <= {1'b0, info_rd_reg[9:0]};
        end
        else if (state_reg == S_ARG)
            wptr_reg <= wptr_reg + 1'b1;
        word_rd_reg <= word_mem[(state_reg == S_ECHK) ?
                                {mod_reg, info_rd_reg[WW-1:0]} :
                                {mod_reg, WW'(wptr_reg + 1'b1)}];
        if (q_pop && !q_txn.bad_module && q_txn.cmd == CMD_WRITE_ENTRY &&
            {22'd0, q_txn.index_or_count} < 32'(MAX_ENTRIES))
        begin
            key_mem [{in_mod, q_txn.index_or_count[EW-1:0]}] <= q_txn.lookup_key;
            res_mem [{in_mod, q_txn.index_or_count[EW-1:0]}] <= q_txn.entry_token;
            info_mem[{in_mod, q_txn.index_or_count[EW-1:0]}] <=
                {q_txn.num_args, q_txn.arg_start};
        end
        if (q_pop && !q_txn.bad_module && q_txn.cmd == CMD_WRITE_WORD &&
            {22'd0, q_txn.index_or_count} < 32'(MAX_ARG_WORDS))
            word_mem[{in_mod, q_txn.index_or_count[WW-1:0]}] <= q_txn.arg0;
    end

endmodule
`default_nettype wire

/* hw/rtl/sorted_table_lookup_with_arg_match.sv */
`default_nettype none
// Per-module sorted lookup table. Pulse start with a command while busy is low.
// Load commands produce no result; each query produces one result, shown with
// done high for exactly one cycle; the receiver cannot stall and must take it
// then. A query runs a binary search probe by probe, then steps down the run
// of equal keys, then tests the argument count and argument words of each
// entry of the run in turn (single-port key, entry and word reads); done is
// registered from the final step.
// A two-deep command queue lets new commands be taken while a query runs.
module sorted_table_lookup_with_arg_match #(
    parameter int MAX_MODULES   = 16,
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_ARG_WORDS = 1024,
    parameter int MAX_ARGS      = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   command,
    input  wire logic [7:0]   module_num,
    input  wire logic [9:0]   index_or_count,
    input  wire logic [31:0]  lookup_key,
    input  wire logic [31:0]  entry_token,
    input  wire logic [2:0]   num_args,
    input  wire logic [9:0]   arg_start,
    input  wire logic [31:0]  arg0,
    input  wire logic [31:0]  arg1,
    input  wire logic [31:0]  arg2,
    input  wire logic [31:0]  arg3,
    output logic              done,
    output logic [1:0]        status,
    output logic [31:0]       result_token
);
    import stl_pkg::*;

    logic q_valid, q_pop;
    txn_t q_txn;

    stl_front #(.MAX_MODULES(MAX_MODULES), .DEPTH(2)) u_front (
        .clk, .rst_n, .start, .busy, .command, .module_num, .index_or_count,
        .lookup_key, .entry_token, .num_args, .arg_start,
        .arg0, .arg1, .arg2, .arg3, .q_valid, .q_txn, .q_pop
    );

    stl_back #(
        .MAX_MODULES(MAX_MODULES), .MAX_ENTRIES(MAX_ENTRIES),
        .MAX_ARG_WORDS(MAX_ARG_WORDS), .MAX_ARGS(MAX_ARGS)
    ) u_back (
        .clk, .rst_n, .q_valid, .q_txn, .q_pop, .done, .status, .result_token
    );

endmodule
`default_nettype wire

/* hw/rtl/stl_checker.sv */
`default_nettype none
module stl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  status,
    input wire logic [31:0] result_token,
    input wire logic        done
);
    import stl_pkg::*;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_HIT |-> result_token == '0)
        else $error("nonzero token on miss");

    a_known_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(status))
        else $error("unknown status on result");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("strobe out of reset");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

endmodule

bind sorted_table_lookup_with_arg_match stl_checker u_chk (
    .clk, .rst_n, .start, .busy, .status, .result_token, .done
);
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
    import stl_pkg::*;

    localparam int NMOD   = 16;
    localparam int NENT   = 256;
    localparam int NWORD  = 1024;
    localparam int NARG   = 4;
    localparam int NITEMS = 1350;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  mod;
        logic [9:0]  idx;
        logic [31:0] key;
        logic [31:0] res;
        logic [2:0]  cnt;
        logic [9:0]  astart;
        logic [31:0] a [4];
    } item_t;

    typedef struct {
        status_t     st;
        logic [31:0] tok;
    } lookup_t;

    typedef struct {
        item_t   it;
        bit      typed;
        lookup_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  command = '0;
    logic [7:0]  module_num = '0;
    logic [9:0]  index_or_count = '0;
    logic [31:0] lookup_key = '0;
    logic [31:0] entry_token = '0;
    logic [2:0]  num_args = '0;
    logic [9:0]  arg_start = '0;
    logic [31:0] arg0 = '0, arg1 = '0, arg2 = '0, arg3 = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] result_token;

    sorted_table_lookup_with_arg_match u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .module_num(module_num), .index_or_count(index_or_count),
        .lookup_key(lookup_key), .entry_token(entry_token), .num_args(num_args),
        .arg_start(arg_start), .arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3),
        .done(done), .status(status), .result_token(result_token)
    );

    always #4 clk = ~clk;

    // shadow copy of the tables
    logic [31:0] key_mem  [NMOD][NENT];
    logic [31:0] res_mem  [NMOD][NENT];
    logic [2:0]  cnt_mem  [NMOD][NENT];
    logic [9:0]  base_mem [NMOD][NENT];
    logic [31:0] word_mem [NMOD][NWORD];
    bit          ent_set  [NMOD][NENT];
    bit          word_set [NMOD][NWORD];
    int          n_ent    [NMOD];

    lookup_t pending_lookups[$];
    int      errors = 0;
    int      n_items = 0;
    int      n_st[4] = '{0, 0, 0, 0};
    int      idle_pct = 0;

    function automatic bit args_equal(int m, int e, item_t t);
        int w;
        if (cnt_mem[m][e] != t.cnt || t.cnt > NARG)
            return 1'b0;
        for (int i = 0; i < t.cnt; i++)
        begin
            w = base_mem[m][e] + i;
            if (w >= NWORD || word_mem[m][w] != t.a[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic lookup_t table_lookup(item_t t);
        lookup_t r;
        int m, lo, hi, mid, first, last;
        r.st  = ST_ABSENT;
        r.tok = '0;
        if (t.mod >= NMOD)
        begin
            r.st = ST_BAD_MODULE;
            return r;
        end
        m  = t.mod;
        lo = 0;
        hi = n_ent[m] - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_mem[m][mid] < t.key)
                lo = mid + 1;
            else if (key_mem[m][mid] > t.key)
                hi = mid - 1;
            else
            begin
                first = mid;
                last  = mid;
                while (first > 0 && key_mem[m][first - 1] == t.key)
                    first--;
                while (last + 1 < n_ent[m] && key_mem[m][last + 1] == t.key)
                    last++;
                for (int e = first; e <= last; e++)
                begin
                    if (args_equal(m, e, t))
                    begin
                        r.st  = ST_HIT;
                        r.tok = res_mem[m][e];
                        return r;
                    end
                end
                r.st = ST_MISMATCH;
                return r;
            end
        end
        return r;
    endfunction

    // a query must never touch an entry or word that was never loaded
    function automatic bit query_safe(item_t t);
        int m;
        if (t.mod >= NMOD)
            return 1'b1;
        m = t.mod;
        for (int e = 0; e < n_ent[m]; e++)
        begin
            if (!ent_set[m][e])
                return 1'b0;
            if (cnt_mem[m][e] <= NARG)
                for (int i = 0; i < cnt_mem[m][e]; i++)
                    if (base_mem[m][e] + i < NWORD && !word_set[m][base_mem[m][e] + i])
                        return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void load_tables(item_t t);
        int m;
        if (t.mod >= NMOD)
            return;
        m = t.mod;
        case (t.cmd)
            CMD_SET_COUNT:   n_ent[m] = (t.idx > NENT) ? NENT : t.idx;
            CMD_WRITE_ENTRY:
                if (t.idx < NENT)
                begin
                    key_mem[m][t.idx]  = t.key;
                    res_mem[m][t.idx]  = t.res;
                    cnt_mem[m][t.idx]  = t.cnt;
                    base_mem[m][t.idx] = t.astart;
                    ent_set[m][t.idx]  = 1'b1;
                end
            CMD_WRITE_WORD:
            begin
                word_mem[m][t.idx] = t.a[0];
                word_set[m][t.idx] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic send(item_t t, bit typed, lookup_t want);
        lookup_t got;
        @(negedge clk);
        command        = t.cmd;
        module_num     = t.mod;
        index_or_count = t.idx;
        lookup_key     = t.key;
        entry_token    = t.res;
        num_args       = t.cnt;
        arg_start      = t.astart;
        arg0           = t.a[0];
        arg1           = t.a[1];
        arg2           = t.a[2];
        arg3           = t.a[3];
        start          = 1'b1;
        do @(posedge clk); while (busy);
        n_items++;
        if (t.cmd == CMD_QUERY)
        begin
            got = typed ? want : table_lookup(t);
            n_st[got.st]++;
            pending_lookups.push_back(got);
        end
        else
            load_tables(t);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_checked(item_t t);
        lookup_t none;
        none.st  = ST_HIT;
        none.tok = '0;
        if (t.cmd == CMD_QUERY && !query_safe(t))
            t.mod = 8'($urandom_range(255, NMOD));
        send(t, 1'b0, none);
    endtask

    function automatic item_t mk(cmd_t c, int m, int idx, logic [31:0] key,
                                 logic [31:0] res, int cnt, int astart,
                                 logic [31:0] a0, logic [31:0] a1,
                                 logic [31:0] a2, logic [31:0] a3);
        item_t t;
        t.cmd = c; t.mod = 8'(m); t.idx = 10'(idx); t.key = key; t.res = res;
        t.cnt = 3'(cnt); t.astart = 10'(astart);
        t.a[0] = a0; t.a[1] = a1; t.a[2] = a2; t.a[3] = a3;
        return t;
    endfunction

    function automatic row_t row(item_t t, bit typed, status_t st, logic [31:0] tok);
        row_t r;
        r.it = t; r.typed = typed; r.want.st = st; r.want.tok = tok;
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t t;
        t.cmd = cmd_t'($urandom_range(3));
        t.mod = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(NMOD - 1));
        t.idx = 10'($urandom); t.key = $urandom; t.res = $urandom;
        t.cnt = 3'($urandom); t.astart = 10'($urandom);
        for (int i = 0; i < 4; i++)
            t.a[i] = $urandom;
        return t;
    endfunction

    // load a word region and a table of n entries, then query it
    task automatic build_and_query(int m, int n);
        item_t t;
        int ws, q, e, nq;
        logic [31:0] k;
        ws = ($urandom_range(3) == 0) ? NWORD - 16 : $urandom_range(NWORD - 17);
        for (int w = ws; w < ws + 16; w++)
        begin
            t = rand_item();
            t.cmd = CMD_WRITE_WORD; t.mod = 8'(m); t.idx = 10'(w);
            t.a[0] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
            send_checked(t);
        end
        k = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom_range(1000);
        for (int i = 0; i < n; i++)
        begin
            t = rand_item();
            t.cmd = CMD_WRITE_ENTRY; t.mod = 8'(m); t.idx = 10'(i);
            k = k + $urandom_range(2);
            // a few tables are left unsorted on purpose
            t.key = ($urandom_range(15) == 0) ? $urandom_range(1000) : k;
            t.cnt = 3'($urandom_range(NARG));
            t.astart = (ws == NWORD - 16) ? 10'($urandom_range(NWORD - 1, ws))
                                          : 10'($urandom_range(ws + 12, ws));
            send_checked(t);
        end
        t = rand_item();
        t.cmd = CMD_SET_COUNT; t.mod = 8'(m); t.idx = 10'(n);
        send_checked(t);
        nq = $urandom_range(10, 3);
        for (int j = 0; j < nq; j++)
        begin
            t = rand_item();
            t.cmd = CMD_QUERY; t.mod = 8'(m);
            e = $urandom_range(n - 1);
            t.key = key_mem[m][e];
            if ($urandom_range(3) == 0)
                t.key = t.key + $urandom_range(2) - 1;
            t.cnt = ($urandom_range(7) == 0) ? 3'($urandom) : cnt_mem[m][e];
            for (int i = 0; i < 4; i++)
            begin
                q = base_mem[m][e] + i;
                if (q < NWORD && i < cnt_mem[m][e])
                    t.a[i] = word_mem[m][q];
            end
            if ($urandom_range(3) == 0)
                t.a[$urandom_range(3)] = $urandom_range(3);
            send_checked(t);
        end
    endtask

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result with no query outstanding: status %0d token %h",
                       status, result_token);
                errors++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    errors++;
                end
                if (result_token !== want.tok)
                begin
                    $error("result_token: expected %h, actual %h", want.tok, result_token);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("sorted_table_lookup_with_arg_match test failed");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        int phase, waited;
        for (int m = 0; m < NMOD; m++)
            n_ent[m] = 0;

        rows.push_back(row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_ABSENT, 0));
        rows.push_back(row(mk(CMD_QUERY, 255, 0, 5, 0, 0, 0, 0, 0, 0, 0), 1,
                           ST_BAD_MODULE, 0));
        rows.push_back(row(mk(CMD_QUERY, 16, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                           ST_BAD_MODULE, 0));
        rows.push_back(row(mk(CMD_WRITE_WORD, 0, 0, 0, 0, 0, 0, '1, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_WORD, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_WORD, 0, 1022, 0, 0, 0, 0, 1, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_WORD, 0, 1023, 0, 0, 0, 0, 32'hA5A5A5A5, 0, 0, 0),
                           0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_ENTRY, 0, 0, 0, '1, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_ENTRY, 0, 1, 5, 7, 2, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_ENTRY, 0, 2, 5, 9, 1, 1023, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_WRITE_ENTRY, 0, 3, '1, 3, 4, 1022, 0, 0, 0, 0), 0, ST_HIT, 0));
        // out-of-range index and bad module: both ignored
        rows.push_back(row(mk(CMD_WRITE_ENTRY, 0, 1023, 6, 1, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_SET_COUNT, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_SET_COUNT, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_HIT, '1));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 5, 0, 2, 0, '1, 0, '1, '1), 1, ST_HIT, 7));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 5, 0, 1, 0, 32'hA5A5A5A5, 0, 0, 0), 1,
                           ST_HIT, 9));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 5, 0, 3, 0, '1, 0, 0, 0), 1, ST_MISMATCH, 0));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 5, 0, 7, 0, '1, 0, 0, 0), 1, ST_MISMATCH, 0));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, '1, 0, 4, 0, 1, 32'hA5A5A5A5, 0, 0), 1,
                           ST_MISMATCH, 0));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 6, 0, 0, 0, 0, 0, 0, 0), 1, ST_ABSENT, 0));
        // oversized count saturates; restore before any query reads module 1
        rows.push_back(row(mk(CMD_SET_COUNT, 1, 1023, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_SET_COUNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_HIT, 0));
        rows.push_back(row(mk(CMD_QUERY, 1, 0, '1, 0, 0, 0, 0, 0, 0, 0), 1, ST_ABSENT, 0));
        rows.push_back(row(mk(CMD_QUERY, 0, 0, 5, 0, 2, 0, '1, 0, 0, 0), 0, ST_HIT, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send(rows[i].it, rows[i].typed, rows[i].want);

        // one full-size table up front
        build_and_query(2, NENT);

        phase = 0;
        while (n_items < NITEMS)
        begin
            if (n_items * 4 / NITEMS > phase)
            begin
                phase = n_items * 4 / NITEMS;
                // hold off until every outstanding query has answered
                if (phase == 2)
                begin
                    @(negedge clk);
                    start = 1'b0;
                    while (pending_lookups.size() != 0)
                        @(posedge clk);
                end
            end
            idle_pct = (phase == 1) ? 79 : (phase == 3) ? 34 : 0;
            if ($urandom_range(9) == 0)
                send_checked(rand_item());
            else
                build_and_query($urandom_range(NMOD - 1), $urandom_range(12, 1));
        end

        @(negedge clk);
        start = 1'b0;
        waited = 0;
        while (pending_lookups.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);

        $display("ran %0d transactions: %0d hits, %0d absent, %0d mismatched, %0d bad module",
                 n_items, n_st[ST_HIT], n_st[ST_ABSENT], n_st[ST_MISMATCH],
                 n_st[ST_BAD_MODULE]);
        if (errors == 0 && pending_lookups.size() == 0)
            $display("sorted_table_lookup_with_arg_match test passed");
        else
            $display("sorted_table_lookup_with_arg_match test failed");
        $finish;
    end
endmodule
`default_nettype wire
